FILE: src/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants of the terminal line discipline
// Character codes, result kinds, configuration register indices, command encoding
// between the front and back ends, and sizes of the line store and command queue.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int AddrW      = $clog2(LINE_DEPTH);
  localparam int LenW       = $clog2(LINE_DEPTH + 1);
  localparam int QDEPTH     = 2;
  localparam int QPtrW      = $clog2(QDEPTH);
  localparam int QCntW      = $clog2(QDEPTH + 1);

  localparam int ByteW = 8;
  localparam int KindW = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_INPUT_MAP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_MODES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NL_ECHO_CR  = 2'd2;

  localparam logic [KindW-1:0] KIND_ECHO    = 3'd0;
  localparam logic [KindW-1:0] KIND_DELIVER = 3'd1;
  localparam logic [KindW-1:0] KIND_INTR    = 3'd2;
  localparam logic [KindW-1:0] KIND_STOP    = 3'd3;
  localparam logic [KindW-1:0] KIND_EOF     = 3'd4;
  localparam logic [KindW-1:0] KIND_WAKE    = 3'd5;

  localparam logic [ByteW-1:0] CH_ETX   = 8'd3;
  localparam logic [ByteW-1:0] CH_EOT   = 8'd4;
  localparam logic [ByteW-1:0] CH_BS    = 8'd8;
  localparam logic [ByteW-1:0] CH_TAB   = 8'd9;
  localparam logic [ByteW-1:0] CH_NL    = 8'd10;
  localparam logic [ByteW-1:0] CH_CR    = 8'd13;
  localparam logic [ByteW-1:0] CH_SUB   = 8'd26;
  localparam logic [ByteW-1:0] CH_SPACE = 8'd32;
  localparam logic [ByteW-1:0] CH_AT    = 8'd64;
  localparam logic [ByteW-1:0] CH_CARET = 8'd94;
  localparam logic [ByteW-1:0] CH_DEL   = 8'd127;

  typedef enum logic [2:0] {
    OP_SIG,
    OP_RAW,
    OP_STORE,
    OP_NL,
    OP_EOF,
    OP_BS
  } op_e;

  typedef enum logic [1:0] {
    ECHO_NONE,
    ECHO_PLAIN,
    ECHO_CARET
  } echo_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] ch;
    logic             sig;
    logic [KindW-1:0] sig_kind;
    echo_e            echo;
    logic [ByteW-1:0] echo_byte;
  } cmd_t;

  typedef struct packed {
    logic [LenW-1:0] line_len;
    logic            busy;
  } back_status_t;

endpackage

FILE: src/tld_rx_if.sv
// ----------------------------------------------------------------------------
// tld_rx_if: received byte channel
// Valid/ready channel carrying one received character per word.
// ----------------------------------------------------------------------------
interface tld_rx_if import tld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/tld_res_if.sv
// ----------------------------------------------------------------------------
// tld_res_if: result channel
// Valid/ready channel carrying one result word: kind, value and last flag.
// ----------------------------------------------------------------------------
interface tld_res_if import tld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] value;
  logic             last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

FILE: src/tld_cfg_if.sv
// ----------------------------------------------------------------------------
// tld_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tld_cfg_if import tld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tld_front.sv
// ----------------------------------------------------------------------------
// tld_front: input mapping and classification
// Holds the configuration registers, applies the CR/NL input mapping and
// turns each received byte into a command for the back end.
// ----------------------------------------------------------------------------
module tld_front import tld_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tld_rx_if.sink       rx,
  tld_cfg_if.sink      cfg,
  input  logic         q_full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic [2:0] input_map_q;
  logic [3:0] local_modes_q;
  logic       nl_cr_q;

  logic [ByteW-1:0] ch;
  logic             drop;
  logic             canon, isig, echo, echonl;
  cmd_t             cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_map_q   <= '0;
      local_modes_q <= '0;
      nl_cr_q       <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_INPUT_MAP:   input_map_q   <= cfg.wdata[2:0];
        CFG_LOCAL_MODES: local_modes_q <= cfg.wdata[3:0];
        CFG_NL_ECHO_CR:  nl_cr_q       <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  assign canon  = local_modes_q[0];
  assign isig   = local_modes_q[1];
  assign echo   = local_modes_q[2];
  assign echonl = local_modes_q[3];

  always_comb begin
    ch   = rx.rx_byte;
    drop = 1'b0;
    if (rx.rx_byte == CH_CR) begin
      if (input_map_q[0]) begin
        ch = CH_NL;
      end else if (input_map_q[1]) begin
        drop = 1'b1;
      end
    end else if (rx.rx_byte == CH_NL && input_map_q[2]) begin
      ch = CH_CR;
    end
  end

  always_comb begin
    cmd.op        = OP_RAW;
    cmd.ch        = ch;
    cmd.sig       = 1'b0;
    cmd.sig_kind  = KIND_INTR;
    cmd.echo      = ECHO_NONE;
    cmd.echo_byte = ch;
    if (ch == CH_SUB || ch == CH_ETX) begin
      if (canon) begin
        cmd.op       = OP_SIG;
        cmd.sig      = isig;
        cmd.sig_kind = (ch == CH_SUB) ? KIND_STOP : KIND_INTR;
      end else if (echo) begin
        cmd.echo = ECHO_CARET;
      end
    end else if (ch == CH_EOT) begin
      if (canon) begin
        cmd.op = OP_EOF;
      end else if (echo) begin
        cmd.echo = ECHO_CARET;
      end
    end else if (ch == CH_DEL || ch == CH_BS) begin
      if (canon) begin
        cmd.op = OP_BS;
        if (echo) begin
          cmd.echo = ECHO_PLAIN;
        end
      end else if (echo || echonl) begin
        cmd.echo      = ECHO_CARET;
        cmd.echo_byte = CH_BS;
      end
    end else if (ch == CH_NL) begin
      if (canon) begin
        cmd.op = OP_NL;
        if (echonl) begin
          cmd.echo = ECHO_PLAIN;
        end
      end else if (echo) begin
        cmd.echo      = ECHO_CARET;
        cmd.echo_byte = nl_cr_q ? CH_CR : CH_NL;
      end else if (echonl) begin
        cmd.echo = ECHO_PLAIN;
      end
    end else if (ch == CH_CR) begin
      if (canon) begin
        cmd.op = OP_STORE;
      end else if (echo) begin
        cmd.echo = ECHO_CARET;
      end
    end else begin
      cmd.op = canon ? OP_STORE : OP_RAW;
      if (echo) begin
        cmd.echo = (ch >= CH_SPACE) ? ECHO_PLAIN : ECHO_CARET;
      end
    end
  end

  assign rx.ready = !q_full_i;
  assign push_o   = rx.valid && !q_full_i && !drop;
  assign cmd_o    = cmd;

endmodule

FILE: src/tld_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tld_cmd_fifo: command queue between front and back ends
// Small register FIFO so that classification and execution stall apart.
// ----------------------------------------------------------------------------
module tld_cmd_fifo import tld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t             mem_q [QDEPTH];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/tld_back.sv
// ----------------------------------------------------------------------------
// tld_back: command execution and result sequencing
// Owns the line store and line length, and emits the result words of each
// command one at a time through an output register.
// ----------------------------------------------------------------------------
module tld_back import tld_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  tld_res_if.source    res,
  output back_status_t status_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SIG     = 4'd1;
  localparam logic [3:0] ST_DELIVER = 4'd2;
  localparam logic [3:0] ST_WAKE    = 4'd3;
  localparam logic [3:0] ST_ECHO_A  = 4'd4;
  localparam logic [3:0] ST_ECHO_B  = 4'd5;
  localparam logic [3:0] ST_REL_RD  = 4'd6;
  localparam logic [3:0] ST_REL_EM  = 4'd7;
  localparam logic [3:0] ST_EOF     = 4'd8;
  localparam logic [3:0] ST_BS      = 4'd9;
  localparam logic [3:0] ST_BS2     = 4'd10;

  logic [3:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [LenW-1:0]  len_q, len_d, idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] out_kind_q;
  logic [ByteW-1:0] out_value_q;
  logic             out_last_q;

  logic             can_emit, emit, e_last;
  logic [KindW-1:0] e_kind;
  logic [ByteW-1:0] e_value;

  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [ByteW-1:0] rdata;
  logic             gone_ctrl;
  logic             raw_echo;

  tld_ram #(.Width(ByteW), .Depth(LINE_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.ch),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign can_emit  = !out_valid_q || res.ready;
  assign gone_ctrl = (rdata < CH_SPACE) && (rdata != CH_NL) && (rdata != CH_CR)
                     && (rdata != CH_TAB);
  assign raw_echo  = (cmd_q.op == OP_RAW) && (cmd_q.echo != ECHO_NONE);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    e_kind  = KIND_ECHO;
    e_value = '0;
    e_last  = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = len_q[AddrW-1:0];
    raddr   = idx_q[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          idx_d = '0;
          if ((cmd_i.op == OP_STORE || cmd_i.op == OP_NL) &&
              (len_q < LenW'(LINE_DEPTH))) begin
            we    = 1'b1;
            len_d = len_q + 1'b1;
          end
          case (cmd_i.op)
            OP_SIG:   state_d = cmd_i.sig ? ST_SIG : ST_WAKE;
            OP_RAW:   state_d = ST_DELIVER;
            OP_STORE: state_d = (cmd_i.echo != ECHO_NONE) ? ST_ECHO_A : ST_IDLE;
            OP_NL:    state_d = ST_REL_RD;
            OP_EOF:   state_d = ST_REL_RD;
            OP_BS: begin
              if (len_q != '0) begin
                len_d   = len_q - 1'b1;
                re      = 1'b1;
                raddr   = len_d[AddrW-1:0];
                state_d = ST_BS;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SIG: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = cmd_q.sig_kind;
          state_d = ST_WAKE;
        end
      end
      ST_DELIVER: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = KIND_DELIVER;
          e_value = cmd_q.ch;
          state_d = ST_WAKE;
        end
      end
      ST_WAKE: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = KIND_WAKE;
          e_last  = !raw_echo;
          state_d = raw_echo ? ST_ECHO_A : ST_IDLE;
        end
      end
      ST_ECHO_A: begin
        if (can_emit) begin
          emit = 1'b1;
          if (cmd_q.echo == ECHO_CARET) begin
            e_value = CH_CARET;
            state_d = ST_ECHO_B;
          end else begin
            e_value = cmd_q.echo_byte;
            e_last  = (cmd_q.op != OP_NL);
            state_d = (cmd_q.op == OP_NL) ? ST_WAKE : ST_IDLE;
          end
        end
      end
      ST_ECHO_B: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_value = cmd_q.echo_byte + CH_AT;
          e_last  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_REL_RD: begin
        if (idx_q < len_q) begin
          re      = 1'b1;
          state_d = ST_REL_EM;
        end else begin
          len_d = '0;
          if (cmd_q.op == OP_NL) begin
            state_d = (cmd_q.echo != ECHO_NONE) ? ST_ECHO_A : ST_WAKE;
          end else begin
            state_d = ST_EOF;
          end
        end
      end
      ST_REL_EM: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = KIND_DELIVER;
          e_value = rdata;
          idx_d   = idx_q + 1'b1;
          state_d = ST_REL_RD;
        end
      end
      ST_EOF: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = KIND_EOF;
          state_d = ST_WAKE;
        end
      end
      ST_BS: begin
        if (cmd_q.echo == ECHO_NONE) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          emit    = 1'b1;
          e_value = CH_BS;
          e_last  = !gone_ctrl;
          state_d = gone_ctrl ? ST_BS2 : ST_IDLE;
        end
      end
      ST_BS2: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_value = CH_BS;
          e_last  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (res.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    if (emit) begin
      out_kind_q  <= e_kind;
      out_value_q <= e_value;
      out_last_q  <= e_last;
    end
  end

  assign res.valid = out_valid_q;
  assign res.kind  = out_kind_q;
  assign res.value = out_value_q;
  assign res.last  = out_last_q;

  assign status_o.line_len = len_q;
  assign status_o.busy     = (state_q != ST_IDLE);

endmodule

FILE: src/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline: canonical/raw terminal input processing
// Received bytes are mapped and classified by a front end, queued, and
// executed by a back end that keeps the line store and emits result words.
// ----------------------------------------------------------------------------
// Each received byte is accepted as soon as the two-entry command
// queue has room, and the back end then takes each command and emits its
// result words one at a time (one to four words for most bytes).
// A canonical backspace on a non-empty line without echo emits no word but
// still makes a line store read before the back end returns to idle.
// A line release reads the line store through its registered read port and
// so alternates a read state and an emit state for each stored byte.
// Ignored carriage returns produce no word and occupy no back-end time.
// The line store needs no clearing after reset.
module terminal_line_discipline import tld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tld_rx_if.sink    rx,
  tld_res_if.source res,
  tld_cfg_if.sink   cfg
);

  logic         push, pop, q_full, q_empty;
  cmd_t         cmd_in, cmd_out;
  back_status_t back_status;

  tld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx),
    .cfg      (cfg),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  tld_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (q_empty)
  );

  tld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .res         (res),
    .status_o    (back_status)
  );

  // The line never grows beyond the store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.line_len <= LenW'(LINE_DEPTH))
    else $error("line length exceeds line store depth");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  // Commands are only taken when the back end has finished the previous one.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !back_status.busy && !q_empty)
    else $error("command taken while back end busy");

  // Signal, end-of-file and wake words carry a zero value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && (res.kind == KIND_INTR || res.kind == KIND_STOP ||
                  res.kind == KIND_EOF || res.kind == KIND_WAKE) |-> res.value == '0)
    else $error("non-byte result carries a value");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for terminal_line_discipline
// Drives received bytes and register writes over valid/ready channels, works
// out every echo, delivery, signal, end-of-file and wake word in an internal
// line-discipline tracker, and compares each result word in order.
// ----------------------------------------------------------------------------
module tb import tld_pkg::*; ();

  localparam int SETTLE = 2 * LINE_DEPTH + 16;
  localparam int LIMIT  = 400000;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic             last;
  } word_t;

  class line_book;
    word_t            pending[$];
    word_t            batch[$];
    logic [ByteW-1:0] line_buf[LINE_DEPTH];
    int unsigned      line_len;
    logic [2:0]       input_map;
    logic [3:0]       local_modes;
    logic             nl_as_cr;
    int               errors;

    function new();
      line_len    = 0;
      input_map   = '0;
      local_modes = '0;
      nl_as_cr    = 1'b0;
      errors      = 0;
    endfunction

    task report_fault(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_INPUT_MAP:   input_map = data[2:0];
        CFG_LOCAL_MODES: local_modes = data[3:0];
        CFG_NL_ECHO_CR:  nl_as_cr = data[0];
        default: ;
      endcase
    endfunction

    function void add(logic [KindW-1:0] kind, logic [ByteW-1:0] value);
      word_t w;
      w.kind  = kind;
      w.value = value;
      w.last  = 1'b0;
      batch.push_back(w);
    endfunction

    function void add_caret(logic [ByteW-1:0] ch);
      add(KIND_ECHO, CH_CARET);
      add(KIND_ECHO, CH_AT + ch);
    endfunction

    function void keep(logic [ByteW-1:0] ch);
      if (line_len < LINE_DEPTH) begin
        line_buf[line_len] = ch;
        line_len++;
      end
    endfunction

    function void release_line();
      for (int i = 0; i < line_len; i++) add(KIND_DELIVER, line_buf[i]);
      line_len = 0;
    endfunction

    function void pass_raw(logic [ByteW-1:0] ch);
      add(KIND_DELIVER, ch);
      add(KIND_WAKE, '0);
    endfunction

    function void take_byte(logic [ByteW-1:0] rx_byte);
      logic [ByteW-1:0] ch;
      logic [ByteW-1:0] gone;
      logic             canon;
      logic             echo;
      ch    = rx_byte;
      canon = local_modes[0];
      echo  = local_modes[2];
      batch.delete();
      if (ch == CH_CR && input_map[0]) begin
        ch = CH_NL;
      end else if (ch == CH_CR && input_map[1]) begin
        return;
      end else if (ch == CH_NL && input_map[2]) begin
        ch = CH_CR;
      end

      if (ch == CH_SUB || ch == CH_ETX) begin
        if (canon) begin
          if (local_modes[1]) add((ch == CH_SUB) ? KIND_STOP : KIND_INTR, '0);
          add(KIND_WAKE, '0);
        end else begin
          pass_raw(ch);
          if (echo) add_caret(ch);
        end
      end else if (ch == CH_EOT) begin
        if (canon) begin
          release_line();
          add(KIND_EOF, '0);
          add(KIND_WAKE, '0);
        end else begin
          pass_raw(ch);
          if (echo) add_caret(ch);
        end
      end else if (ch == CH_DEL || ch == CH_BS) begin
        if (canon) begin
          if (line_len == 0) return;
          line_len--;
          gone = line_buf[line_len];
          if (echo) begin
            if (gone < CH_SPACE && gone != CH_NL && gone != CH_CR && gone != CH_TAB)
              add(KIND_ECHO, CH_BS);
            add(KIND_ECHO, CH_BS);
          end
        end else begin
          pass_raw(ch);
          if (local_modes[2] || local_modes[3]) add_caret(CH_BS);
        end
      end else if (ch == CH_NL) begin
        if (canon) begin
          keep(ch);
          release_line();
          if (local_modes[3]) add(KIND_ECHO, CH_NL);
          add(KIND_WAKE, '0);
        end else begin
          pass_raw(ch);
          if (echo) add_caret(nl_as_cr ? CH_CR : CH_NL);
          else if (local_modes[3]) add(KIND_ECHO, CH_NL);
        end
      end else if (ch == CH_CR) begin
        if (canon) begin
          keep(ch);
        end else begin
          pass_raw(ch);
          if (echo) add_caret(ch);
        end
      end else begin
        if (canon) keep(ch);
        else pass_raw(ch);
        if (echo) begin
          if (ch >= CH_SPACE) add(KIND_ECHO, ch);
          else add_caret(ch);
        end
      end

      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    task match_word(logic [KindW-1:0] kind, logic [ByteW-1:0] value, logic last);
      word_t w;
      if (pending.size() == 0) begin
        report_fault($sformatf("unexpected word kind %0d value %02h last %0b",
                               kind, value, last));
        return;
      end
      w = pending.pop_front();
      if (kind !== w.kind || value !== w.value || last !== w.last)
        report_fault($sformatf("got kind %0d value %02h last %0b, want %0d %02h %0b",
                               kind, value, last, w.kind, w.value, w.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_start;
  logic calm;
  int   cycle_count = 0;
  int   sent = 0;

  line_book book = new();

  tld_rx_if  rx ();
  tld_res_if res ();
  tld_cfg_if cfg ();

  terminal_line_discipline dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx),
    .res    (res),
    .cfg    (cfg)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res.valid === 1'b1 && res.ready)
        book.match_word(res.kind, res.value, res.last);
      if (hold_start) hold_left = 400;
      else if (hold_left > 0) hold_left--;
      res.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 17);
    end
  end

  task automatic pause();
    while (!calm && $urandom_range(99) < 17) begin
      rx.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [ByteW-1:0] b);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk_i);
    while (!rx.ready) @(posedge clk_i);
    book.take_byte(b);
    sent++;
    pause();
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    book.set_reg(idx, data);
  endtask

  task automatic configure(logic [2:0] map, logic [3:0] modes, logic nl_cr);
    drain();
    write_reg(CFG_INPUT_MAP, {1'b0, map});
    write_reg(CFG_LOCAL_MODES, modes);
    write_reg(CFG_NL_ECHO_CR, {3'b000, nl_cr});
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return ByteW'($urandom_range(32, 126));
    if (r < 65) return ByteW'($urandom_range(128, 255));
    if (r < 75) return ($urandom_range(1) != 0) ? CH_BS : CH_DEL;
    if (r < 85) return ByteW'($urandom_range(31));
    return ByteW'($urandom_range(255));
  endfunction

  function automatic logic [ByteW-1:0] pick_end();
    case ($urandom_range(5))
      0, 1:    return CH_NL;
      2:       return CH_CR;
      3:       return CH_EOT;
      4:       return CH_ETX;
      default: return CH_SUB;
    endcase
  endfunction

  task automatic send_line(int n);
    for (int i = 0; i < n; i++) send_byte(pick_byte());
    send_byte(pick_end());
  endtask

  task automatic random_phase(int count);
    int stop_at;
    int left;
    int n;
    stop_at = sent + count;
    while (sent < stop_at) begin
      left = stop_at - sent;
      if ($urandom_range(99) < 15) begin
        send_byte(ByteW'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 10) n = $urandom_range(30, 40);
        else n = $urandom_range(0, 8);
        if (n > left - 1) n = left - 1;
        send_line(n);
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    rx.valid      <= 1'b0;
    rx.rx_byte    <= '0;
    cfg.valid     <= 1'b0;
    cfg.reg_index <= CFG_INPUT_MAP;
    cfg.wdata     <= '0;
    hold_start    <= 1'b0;
    calm          <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(3'd0, 4'b0111, 1'b0);
    send_byte(8'h61); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    send_byte(CH_TAB); send_byte(8'h01); send_byte(CH_BS); send_byte(CH_DEL);
    send_byte(CH_CR); send_byte(CH_ETX); send_byte(CH_SUB); send_byte(CH_NL);
    send_byte(CH_BS); send_byte(8'h78); send_byte(CH_EOT);
    configure(3'd1, 4'b1011, 1'b0);
    send_byte(8'h41); send_byte(CH_CR);
    configure(3'd2, 4'b0101, 1'b0);
    send_byte(CH_CR); send_byte(CH_ETX);
    configure(3'd4, 4'b0100, 1'b1);
    send_byte(CH_NL); send_byte(CH_BS);
    configure(3'd0, 4'b0100, 1'b1);
    send_byte(CH_NL);
    configure(3'd0, 4'b1000, 1'b0);
    send_byte(CH_NL); send_byte(CH_DEL);

    configure(3'd0, 4'b0000, 1'b0);
    random_phase(21);
    configure(3'd7, 4'b1111, 1'b1);
    random_phase(21);
    configure(3'd0, 4'b0111, 1'b0);
    calm       <= 1'b1;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    send_line(40);
    random_phase(18);
    calm <= 1'b0;
    configure(3'd1, 4'b1111, 1'b0);
    random_phase(21);
    configure(3'd2, 4'b0101, 1'b1);
    random_phase(21);
    configure(3'd4, 4'b0011, 1'b0);
    random_phase(21);
    configure(3'd3, 4'b1110, 1'b1);
    random_phase(21);
    configure(3'd6, 4'b1001, 1'b0);
    random_phase(21);

    drain();
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/tld_pkg.sv
src/tld_rx_if.sv
src/tld_res_if.sv
src/tld_cfg_if.sv
src/tld_ram.sv
src/tld_front.sv
src/tld_cmd_fifo.sv
src/tld_back.sv
src/terminal_line_discipline.sv
bench/tb.sv
